// ----- rtl/bba_pkg.sv -----
// Package: shared types, codes and constants of the block allocator.
package bba_pkg;

  localparam int NUM_BLOCKS_DFLT = 256;
  localparam int USED_W          = 8;   // used-bitmap bits per memory word
  localparam int USED_BW         = 3;   // bit select width inside a word

  localparam logic [7:0] FIRST_ALLOC_RST = 8'd3;
  localparam logic [8:0] LINK_END        = 9'h1FF;

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_ALLOC_EXT = 3'd1,
    OP_FREE      = 3'd2,
    OP_READ_LINK = 3'd3,
    OP_WRITE_LINK= 3'd4,
    OP_FIND_LAST = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_WALK   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_UCHK,
    S_EXT,
    S_FREE_WR,
    S_LRD,
    S_WALK,
    S_DONE
  } state_t;

endpackage

// ----- rtl/bba_req_if.sv -----
// Interface: request channel of the block allocator.
interface bba_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [7:0]        block;
  logic signed [8:0] link_value;

  modport source (output valid, output operation, output block, output link_value,
                  input ready);
  modport sink   (input valid, input operation, input block, input link_value,
                  output ready);
endinterface

// ----- rtl/bba_rsp_if.sv -----
// Interface: result channel of the block allocator.
interface bba_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [8:0] result_block;

  modport source (output valid, output status, output result_block, input ready);
  modport sink   (input valid, input status, input result_block, output ready);
endinterface

// ----- rtl/bitmap_block_allocator_with_chain_top.sv -----
// Top level: bitmap first-fit block allocator with per-block link chain.
// Allocate scans the used bitmap word by word, with an extra step to write the
//   extension link for allocate-extend; find last follows the chain hop by hop.
// One request at a time; the result register lets the next request in while
//   a result waits.
// Reset: control, first_allocatable (=3) and per-entry valid bits cleared;
//   unwritten entries read as zero, so no clearing pass is needed.
module bitmap_block_allocator_with_chain_top #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DFLT
) (
  input  logic       clk,
  input  logic       rst_n,
  bba_req_if.sink    in_req,
  bba_rsp_if.source  out_rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Pool is capped by the 8-bit block index.
  localparam int POOL_SPAN = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
  localparam int AW        = $clog2(POOL_SPAN);
  localparam int NW        = (POOL_SPAN + bba_pkg::USED_W - 1) / bba_pkg::USED_W;
  localparam int WAW       = (NW > 1) ? $clog2(NW) : 1;
  localparam int HW        = $clog2(NUM_BLOCKS + 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  bba_pkg::state_t  state_r, state_nxt;
  logic [7:0]       fa_r;                      // first_allocatable
  logic [2:0]       op_r, op_nxt;
  logic [7:0]       blk_r, blk_nxt;
  logic [8:0]       lv_r, lv_nxt;
  logic [WAW:0]     curw_r, curw_nxt;          // next word to search from
  logic [WAW-1:0]   uw_r, uw_nxt;              // word being checked
  logic [AW-1:0]    cur_r, cur_nxt;            // chain walk position
  logic [HW-1:0]    hops_r, hops_nxt;
  logic [8:0]       idx_r, idx_nxt;            // block handed out
  logic [1:0]       st_r, st_nxt;              // pending result
  logic [8:0]       res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r;
  logic [8:0]       out_result_r;
  logic             out_load;

  // ---------------------------------------------------------------------------
  // Link table memory: one write, one registered read per cycle
  // ---------------------------------------------------------------------------
  logic [8:0]          link_mem [POOL_SPAN];
  logic [POOL_SPAN-1:0] link_vld_r;
  logic                lk_re, lk_we;
  logic [AW-1:0]       lk_raddr, lk_waddr;
  logic [8:0]          lk_wdata, lk_rdata_r;
  logic                lk_rvld_r;

  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    if (lk_re) lk_rdata_r <= link_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
      lk_rvld_r  <= 1'b0;
    end else begin
      if (lk_we) link_vld_r[lk_waddr] <= 1'b1;
      if (lk_re) lk_rvld_r <= link_vld_r[lk_raddr];
    end
  end

  // never-written entries read as zero (cleared disk)
  logic [8:0] lk_data;
  assign lk_data = lk_rvld_r ? lk_rdata_r : 9'd0;

  // ---------------------------------------------------------------------------
  // Used bitmap memory, USED_W bits a word, with a full flag per word
  // ---------------------------------------------------------------------------
  logic [bba_pkg::USED_W-1:0] used_mem [NW];
  logic [NW-1:0]              used_vld_r;
  logic [NW-1:0]              full_r;
  logic                       u_re, u_we, u_full_wr;
  logic [WAW-1:0]             u_raddr, u_waddr;
  logic [bba_pkg::USED_W-1:0] u_wdata, u_rdata_r;
  logic                       u_rvld_r;

  always_ff @(posedge clk) begin
    if (u_we) used_mem[u_waddr] <= u_wdata;
    if (u_re) u_rdata_r <= used_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_vld_r <= '0;
      full_r     <= '0;
      u_rvld_r   <= 1'b0;
    end else begin
      if (u_we) begin
        used_vld_r[u_waddr] <= 1'b1;
        full_r[u_waddr]     <= u_full_wr;
      end
      if (u_re) u_rvld_r <= used_vld_r[u_raddr];
    end
  end

  logic [bba_pkg::USED_W-1:0] u_raw;
  assign u_raw = u_rvld_r ? u_rdata_r : '0;

  // ---------------------------------------------------------------------------
  // Allocation search helpers
  // ---------------------------------------------------------------------------
  // first word at or above curw_r that still has a free in-pool bit
  logic           fw_found;
  logic [WAW-1:0] fw_idx;

  always_comb begin
    fw_found = 1'b0;
    fw_idx   = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (!full_r[i] && ((WAW+1)'(i) >= curw_r)) begin
        fw_found = 1'b1;
        fw_idx   = WAW'(i);
      end
    end
  end

  // word under check: out-of-pool bits and bits below first_allocatable count as used
  logic [bba_pkg::USED_W-1:0]  pad_mask, low_mask, eff_word, free_bits;
  logic [bba_pkg::USED_BW-1:0] free_pos;
  logic                        free_any;
  logic                        is_start_word;

  assign is_start_word = (8'(uw_r) == {3'b000, fa_r[7:3]});

  always_comb begin
    for (int b = 0; b < bba_pkg::USED_W; b++) begin
      pad_mask[b] = (10'({uw_r, bba_pkg::USED_BW'(b)}) >= 10'(POOL_SPAN));
      low_mask[b] = is_start_word && (bba_pkg::USED_BW'(b) < fa_r[2:0]);
    end
    eff_word  = u_raw | pad_mask | low_mask;
    free_bits = ~eff_word;
    free_any  = |free_bits;
    free_pos  = '0;
    for (int b = bba_pkg::USED_W - 1; b >= 0; b--) begin
      if (free_bits[b]) free_pos = bba_pkg::USED_BW'(b);
    end
  end

  logic [bba_pkg::USED_W-1:0] set_word;
  assign set_word = u_raw | (bba_pkg::USED_W'(1) << free_pos);

  // ---------------------------------------------------------------------------
  // Request decode helpers
  // ---------------------------------------------------------------------------
  logic in_blk_ok, blk_r_ok, fa_ok;
  assign in_blk_ok = ({1'b0, in_req.block} < 9'(POOL_SPAN));
  assign blk_r_ok  = ({1'b0, blk_r} < 9'(POOL_SPAN));
  assign fa_ok     = ({1'b0, fa_r} < 9'(POOL_SPAN));

  logic [bba_pkg::USED_W-1:0] free_clr;
  assign free_clr = u_raw & ~(bba_pkg::USED_W'(1) << blk_r[bba_pkg::USED_BW-1:0]);

  // ---------------------------------------------------------------------------
  // Sequencer. One request in flight; reads never target an entry written in
  // the same cycle, so no forwarding path is needed.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_IDLE;
      fa_r        <= bba_pkg::FIRST_ALLOC_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) fa_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    blk_r  <= blk_nxt;
    lv_r   <= lv_nxt;
    curw_r <= curw_nxt;
    uw_r   <= uw_nxt;
    cur_r  <= cur_nxt;
    hops_r <= hops_nxt;
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_status_r <= st_r;
      out_result_r <= res_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    blk_nxt   = blk_r;
    lv_nxt    = lv_r;
    curw_nxt  = curw_r;
    uw_nxt    = uw_r;
    cur_nxt   = cur_r;
    hops_nxt  = hops_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    lk_re     = 1'b0;
    lk_raddr  = in_req.block[AW-1:0];
    lk_we     = 1'b0;
    lk_waddr  = blk_r[AW-1:0];
    lk_wdata  = lv_r;
    u_re      = 1'b0;
    u_raddr   = WAW'(in_req.block >> bba_pkg::USED_BW);
    u_we      = 1'b0;
    u_waddr   = uw_r;
    u_wdata   = set_word;
    u_full_wr = &(set_word | pad_mask);

    unique case (state_r)
      bba_pkg::S_IDLE: begin
        if (in_req.valid) begin
          op_nxt  = in_req.operation;
          blk_nxt = in_req.block;
          lv_nxt  = in_req.link_value;
          st_nxt  = bba_pkg::ST_OK;
          res_nxt = bba_pkg::LINK_END;
          state_nxt = bba_pkg::S_DONE;
          unique case (in_req.operation) inside
            bba_pkg::OP_ALLOC, bba_pkg::OP_ALLOC_EXT: begin
              if (fa_ok) begin
                curw_nxt  = (WAW+1)'(fa_r >> bba_pkg::USED_BW);
                state_nxt = bba_pkg::S_FIND;
              end else begin
                st_nxt = bba_pkg::ST_NOFREE;
              end
            end
            bba_pkg::OP_FREE: begin
              if (in_blk_ok) begin
                u_re      = 1'b1;
                state_nxt = bba_pkg::S_FREE_WR;
              end
            end
            bba_pkg::OP_READ_LINK: begin
              if (in_blk_ok) begin
                lk_re     = 1'b1;
                state_nxt = bba_pkg::S_LRD;
              end
            end
            bba_pkg::OP_WRITE_LINK: begin
              if (in_blk_ok) begin
                lk_we    = 1'b1;
                lk_waddr = in_req.block[AW-1:0];
                lk_wdata = in_req.link_value;
              end
            end
            bba_pkg::OP_FIND_LAST: begin
              if (in_blk_ok) begin
                lk_re     = 1'b1;
                cur_nxt   = in_req.block[AW-1:0];
                hops_nxt  = '0;
                state_nxt = bba_pkg::S_WALK;
              end else begin
                st_nxt = bba_pkg::ST_WALK;
              end
            end
            default: ;  // unused codes: no action, answered with ST_OK and LINK_END
          endcase
        end
      end

      bba_pkg::S_FIND: begin
        if (fw_found) begin
          u_re      = 1'b1;
          u_raddr   = fw_idx;
          uw_nxt    = fw_idx;
          state_nxt = bba_pkg::S_UCHK;
        end else begin
          st_nxt    = bba_pkg::ST_NOFREE;
          res_nxt   = bba_pkg::LINK_END;
          state_nxt = bba_pkg::S_DONE;
        end
      end

      bba_pkg::S_UCHK: begin
        if (free_any) begin
          idx_nxt  = 9'({uw_r, free_pos});
          u_we     = 1'b1;
          lk_we    = 1'b1;
          lk_waddr = AW'({uw_r, free_pos});
          lk_wdata = bba_pkg::LINK_END;
          st_nxt   = bba_pkg::ST_OK;
          res_nxt  = 9'({uw_r, free_pos});
          if ((op_r == bba_pkg::OP_ALLOC_EXT) && blk_r_ok) begin
            state_nxt = bba_pkg::S_EXT;
          end else begin
            state_nxt = bba_pkg::S_DONE;
          end
        end else begin
          curw_nxt  = (WAW+1)'(uw_r) + (WAW+1)'(1);
          state_nxt = bba_pkg::S_FIND;
        end
      end

      bba_pkg::S_EXT: begin
        // after the new block's end mark, so a self-extend links to itself
        lk_we     = 1'b1;
        lk_wdata  = idx_r;
        state_nxt = bba_pkg::S_DONE;
      end

      bba_pkg::S_FREE_WR: begin
        u_we      = 1'b1;
        u_waddr   = WAW'(blk_r >> bba_pkg::USED_BW);
        u_wdata   = free_clr;
        u_full_wr = 1'b0;
        lk_we     = 1'b1;
        lk_wdata  = 9'd0;
        state_nxt = bba_pkg::S_DONE;
      end

      bba_pkg::S_LRD: begin
        res_nxt   = lk_data;
        state_nxt = bba_pkg::S_DONE;
      end

      bba_pkg::S_WALK: begin
        if (lk_data == bba_pkg::LINK_END) begin
          st_nxt    = bba_pkg::ST_OK;
          res_nxt   = 9'(cur_r);
          state_nxt = bba_pkg::S_DONE;
        end else if (lk_data[8] || ({1'b0, lk_data[7:0]} >= 9'(POOL_SPAN)) ||
                     (hops_r == HW'(NUM_BLOCKS))) begin
          st_nxt    = bba_pkg::ST_WALK;
          res_nxt   = bba_pkg::LINK_END;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          lk_re    = 1'b1;
          lk_raddr = lk_data[AW-1:0];
          cur_nxt  = lk_data[AW-1:0];
          hops_nxt = hops_r + HW'(1);
        end
      end

      bba_pkg::S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = bba_pkg::S_IDLE;
        end
      end

      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) out_valid_nxt = 1'b0;
    if (out_load)      out_valid_nxt = 1'b1;
  end

  assign in_req.ready         = (state_r == bba_pkg::S_IDLE);
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.result_block = out_result_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fail_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status != bba_pkg::ST_OK) |->
      (out_rsp.result_block == bba_pkg::LINK_END))
    else $error("failure result not -1");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("second request taken while busy");

  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bba_pkg::S_WALK) |-> ({1'b0, hops_r} <= (HW+1)'(NUM_BLOCKS)))
    else $error("walk hop count beyond bound");

endmodule
